FILE: src/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for the pressure/temperature compensator
// Calibration coefficient bundle, pipeline sideband and result words, and the
// fixed constants of the integer compensation scheme.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

    // Configuration register indexes.
    localparam logic [7:0] CFG_TEMP_CALIB  = 8'd0;
    localparam logic [7:0] CFG_PRESS_LO    = 8'd1;
    localparam logic [7:0] CFG_PRESS_HI    = 8'd2;
    localparam logic [7:0] CFG_PRESS_NINE  = 8'd3;

    // Constants of the compensation formulae.
    localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
    localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
    localparam logic [11:0]        PRESS_SCALE = 12'd3125;
    localparam logic [63:0]        ROUND_HALF  = 64'd128;
    localparam logic [63:0]        DIV_BIAS    = 64'h0000_8000_0000_0000;

    // Pipeline depths.
    localparam int FRONT_LAT = 13;
    localparam int DIV_STEPS = 64;
    localparam int BACK_LAT  = 7;

    // Unpacked calibration coefficients, each sixteen bits.
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_coef;

    // Values that ride alongside the division.
    typedef struct packed {
        logic        status;
        logic [31:0] temp;
        logic [31:0] fine;
    } t_side;

    // One result word.
    typedef struct packed {
        logic        status;
        logic [31:0] temp_centi;
        logic [31:0] fine_temp;
        logic [31:0] pressure;
    } t_result;

endpackage

`default_nettype wire

FILE: src/ptc_front.sv
// ----------------------------------------------------------------------------
// ptc_front: temperature path and pressure terms ahead of the division
// Thirteen register stages form the fine temperature, the compensated
// temperature, the signed numerator and divisor, and their magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [19:0]          i_adc_temp,
    input  wire logic [19:0]          i_adc_press,
    input  wire ptc_pkg::t_coef       i_coef,
    output logic                      o_valid,
    output logic [63:0]               o_num,
    output logic [63:0]               o_den,
    output logic                      o_neg,
    output ptc_pkg::t_side            o_side
);

    logic [ptc_pkg::FRONT_LAT-1:0] r_vld;

    // Stage registers.
    logic signed [17:0] r1_d1;
    logic signed [16:0] r1_d2;
    logic [19:0]        r1_ap, r2_ap, r3_ap, r4_ap, r5_ap, r6_ap, r7_ap, r8_ap, r9_ap;
    logic [31:0]        r2_m1, r2_m2;
    logic signed [31:0] r3_a1;
    logic [31:0]        r3_m3;
    logic signed [31:0] r4_fine;
    logic [31:0]        r5_temp, r5_fine;
    logic signed [32:0] r5_v1;
    logic [63:0]        r6_vsq;
    logic signed [48:0] r6_vp5, r6_vp2, r7_vp5, r7_vp2, r8_vp5, r8_vp2;
    logic signed [48:0] r7_l6, r7_l3;
    logic [31:0]        r7_h6, r7_h3;
    logic [63:0]        r8_v2a, r8_q3;
    logic [63:0]        r9_v2, r9_v1b;
    logic [63:0]        r10_x, r10_nd;
    logic [47:0]        r11_xl;
    logic [31:0]        r11_xh, r11_nh;
    logic [43:0]        r11_nl;
    logic [63:0]        r12_div, r12_num;
    logic [31:0]        r6_temp, r7_temp, r8_temp, r9_temp, r10_temp, r11_temp, r12_temp;
    logic [31:0]        r6_fine, r7_fine, r8_fine, r9_fine, r10_fine, r11_fine, r12_fine;
    logic [63:0]        r13_num, r13_den;
    logic               r13_neg;
    ptc_pkg::t_side     r13_side;

    // Combinational terms.
    logic signed [17:0] n1_d1;
    logic signed [16:0] n1_d2;
    logic signed [33:0] w_m1, w_m2;
    logic signed [31:0] w_sq;
    logic signed [47:0] w_m3;
    logic [31:0]        w_t5;
    logic signed [31:0] w_temp;
    logic signed [65:0] w_vsq;
    logic signed [48:0] w_vp5, w_vp2, w_l6, w_l3;
    logic [63:0]        w_v2, w_v1b, w_q3s, w_dv, w_div, w_num;
    logic [20:0]        w_pd;

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ptc_pkg::FRONT_LAT-2:0], i_valid};
        end
    end

    // Temperature differences against T1.
    assign n1_d1 = $signed({1'b0, i_adc_temp[19:3]}) - $signed({1'b0, i_coef.t1, 1'b0});
    assign n1_d2 = $signed({1'b0, i_adc_temp[19:4]}) - $signed({1'b0, i_coef.t1});

    // Temperature products, each wrapped to 32 bits.
    assign w_m1 = r1_d1 * $signed(i_coef.t2);
    assign w_m2 = r1_d2 * r1_d2;
    assign w_sq = $signed(r2_m2) >>> 12;
    assign w_m3 = w_sq * $signed(i_coef.t3);

    // Temperature in hundredths: (fine * 5 + 128) >> 8 in 32 bits.
    assign w_t5   = 32'(r4_fine) + 32'(r4_fine <<< 2) + 32'd128;
    assign w_temp = $signed(w_t5) >>> 8;

    // Pressure polynomial terms in v1 = fine - 128000.
    assign w_vsq = r5_v1 * r5_v1;
    assign w_vp5 = r5_v1 * $signed(i_coef.p5);
    assign w_vp2 = r5_v1 * $signed(i_coef.p2);
    assign w_l6  = $signed({1'b0, r6_vsq[31:0]}) * $signed(i_coef.p6);
    assign w_l3  = $signed({1'b0, r6_vsq[31:0]}) * $signed(i_coef.p3);

    // Sums of the polynomial terms, 64-bit wrapping.
    assign w_q3s = 64'($signed(r8_q3) >>> 8);
    assign w_v2  = r8_v2a + ({{15{r8_vp5[48]}}, r8_vp5} << 17)
                 + ({{48{i_coef.p4[15]}}, i_coef.p4} << 35);
    assign w_v1b = w_q3s + ({{15{r8_vp2[48]}}, r8_vp2} << 12);

    // Raw pressure offset from full scale.
    assign w_pd = ptc_pkg::PRESS_FULL - {1'b0, r9_ap};

    // Divisor and numerator assembled from their partial products.
    assign w_dv  = {16'd0, r11_xl} + {r11_xh, 32'd0};
    assign w_div = 64'($signed(w_dv) >>> 33);
    assign w_num = {20'd0, r11_nl} + {r11_nh, 32'd0};

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d1    <= n1_d1;
            r1_d2    <= n1_d2;
            r1_ap    <= i_adc_press;

            r2_m1    <= w_m1[31:0];
            r2_m2    <= w_m2[31:0];
            r2_ap    <= r1_ap;

            r3_a1    <= $signed(r2_m1) >>> 11;
            r3_m3    <= w_m3[31:0];
            r3_ap    <= r2_ap;

            r4_fine  <= r3_a1 + ($signed(r3_m3) >>> 14);
            r4_ap    <= r3_ap;

            r5_temp  <= w_temp;
            r5_fine  <= r4_fine;
            r5_v1    <= $signed({r4_fine[31], r4_fine}) - ptc_pkg::FINE_OFFSET;
            r5_ap    <= r4_ap;

            r6_vsq   <= w_vsq[63:0];
            r6_vp5   <= w_vp5;
            r6_vp2   <= w_vp2;
            r6_ap    <= r5_ap;
            r6_temp  <= r5_temp;
            r6_fine  <= r5_fine;

            r7_l6    <= w_l6;
            r7_h6    <= 32'($signed(r6_vsq[63:32]) * $signed(i_coef.p6));
            r7_l3    <= w_l3;
            r7_h3    <= 32'($signed(r6_vsq[63:32]) * $signed(i_coef.p3));
            r7_vp5   <= r6_vp5;
            r7_vp2   <= r6_vp2;
            r7_ap    <= r6_ap;
            r7_temp  <= r6_temp;
            r7_fine  <= r6_fine;

            r8_v2a   <= {{15{r7_l6[48]}}, r7_l6} + {r7_h6, 32'd0};
            r8_q3    <= {{15{r7_l3[48]}}, r7_l3} + {r7_h3, 32'd0};
            r8_vp5   <= r7_vp5;
            r8_vp2   <= r7_vp2;
            r8_ap    <= r7_ap;
            r8_temp  <= r7_temp;
            r8_fine  <= r7_fine;

            r9_v2    <= w_v2;
            r9_v1b   <= w_v1b;
            r9_ap    <= r8_ap;
            r9_temp  <= r8_temp;
            r9_fine  <= r8_fine;

            r10_x    <= r9_v1b + ptc_pkg::DIV_BIAS;
            r10_nd   <= ({43'd0, w_pd} << 31) - r9_v2;
            r10_temp <= r9_temp;
            r10_fine <= r9_fine;

            r11_xl   <= r10_x[31:0] * i_coef.p1;
            r11_xh   <= 32'(r10_x[63:32] * {16'd0, i_coef.p1});
            r11_nl   <= r10_nd[31:0] * ptc_pkg::PRESS_SCALE;
            r11_nh   <= 32'(r10_nd[63:32] * {20'd0, ptc_pkg::PRESS_SCALE});
            r11_temp <= r10_temp;
            r11_fine <= r10_fine;

            r12_div  <= w_div;
            r12_num  <= w_num;
            r12_temp <= r11_temp;
            r12_fine <= r11_fine;

            // Magnitudes and the quotient sign for the unsigned divider.
            r13_num         <= r12_num[63] ? (64'd0 - r12_num) : r12_num;
            r13_den         <= r12_div[63] ? (64'd0 - r12_div) : r12_div;
            r13_neg         <= r12_num[63] ^ r12_div[63];
            r13_side.status <= (r12_div == 64'd0);
            r13_side.temp   <= r12_temp;
            r13_side.fine   <= r12_fine;
        end
    end

    assign o_valid = r_vld[ptc_pkg::FRONT_LAT-1];
    assign o_num   = r13_num;
    assign o_den   = r13_den;
    assign o_neg   = r13_neg;
    assign o_side  = r13_side;

endmodule

`default_nettype wire

FILE: src/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div: pipelined 64-bit unsigned restoring divider
// One quotient bit per register stage; the sign and sideband values travel
// with each word so that every stage holds an independent division.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [63:0]     i_num,
    input  wire logic [63:0]     i_den,
    input  wire logic            i_neg,
    input  wire ptc_pkg::t_side  i_side,
    output logic                 o_valid,
    output logic [63:0]          o_quo,
    output logic                 o_neg,
    output ptc_pkg::t_side       o_side
);

    logic [ptc_pkg::DIV_STEPS-1:0] r_vld;
    logic [63:0]    r_rem  [ptc_pkg::DIV_STEPS];
    logic [63:0]    r_num  [ptc_pkg::DIV_STEPS];
    logic [63:0]    r_den  [ptc_pkg::DIV_STEPS];
    logic           r_neg  [ptc_pkg::DIV_STEPS];
    ptc_pkg::t_side r_side [ptc_pkg::DIV_STEPS];

    // Valid bits shift along with the division steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ptc_pkg::DIV_STEPS-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < ptc_pkg::DIV_STEPS; k++) begin : g_step
        logic [63:0]    w_rem, w_num, w_den;
        logic           w_neg;
        ptc_pkg::t_side w_side;
        logic [64:0]    w_trial;
        logic           w_ge;

        // The first step starts from a zero partial remainder.
        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_num  = i_num;
            assign w_den  = i_den;
            assign w_neg  = i_neg;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_num  = r_num[k-1];
            assign w_den  = r_den[k-1];
            assign w_neg  = r_neg[k-1];
            assign w_side = r_side[k-1];
        end

        // Bring down the next numerator bit and try the subtraction.
        assign w_trial = {w_rem, w_num[63]};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? 64'(w_trial - {1'b0, w_den}) : w_trial[63:0];
                r_num[k]  <= {w_num[62:0], w_ge};
                r_den[k]  <= w_den;
                r_neg[k]  <= w_neg;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[ptc_pkg::DIV_STEPS-1];
    assign o_quo   = r_num[ptc_pkg::DIV_STEPS-1];
    assign o_neg   = r_neg[ptc_pkg::DIV_STEPS-1];
    assign o_side  = r_side[ptc_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

FILE: src/ptc_back.sv
// ----------------------------------------------------------------------------
// ptc_back: pressure terms after the division and final rounding
// Seven register stages apply the P7 to P9 corrections, round from Q24.8 and
// clear the pressure of a word marked not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [63:0]     i_quo,
    input  wire logic            i_neg,
    input  wire ptc_pkg::t_side  i_side,
    input  wire ptc_pkg::t_coef  i_coef,
    output logic                 o_valid,
    output ptc_pkg::t_result     o_res
);

    logic [ptc_pkg::BACK_LAT-1:0] r_vld;

    logic [63:0]        r1_p, r2_p, r3_p, r4_p, r5_p;
    logic [63:0]        r2_a, r3_a;
    logic signed [48:0] r2_al, r2_pl;
    logic [31:0]        r2_ah, r2_ph;
    logic [63:0]        r3_b, r3_v2, r4_v2, r5_v2;
    logic [63:0]        r4_ll;
    logic [31:0]        r4_lh, r4_hl;
    logic [63:0]        r5_v1;
    logic [63:0]        r6_t;
    ptc_pkg::t_side     r1_side, r2_side, r3_side, r4_side, r5_side, r6_side;
    ptc_pkg::t_result   r7_res;

    logic [63:0]        w_a, w_b, w_pp8, w_c, w_s, w_u;
    logic signed [48:0] w_al, w_pl;

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[ptc_pkg::BACK_LAT-2:0], i_valid};
        end
    end

    // Low halves of the P9 and P8 products.
    assign w_a  = 64'($signed(r1_p) >>> 13);
    assign w_al = $signed({1'b0, w_a[31:0]}) * $signed(i_coef.p9);
    assign w_pl = $signed({1'b0, r1_p[31:0]}) * $signed(i_coef.p8);

    // Products assembled from their halves, 64-bit wrapping.
    assign w_b   = {{15{r2_al[48]}}, r2_al} + {r2_ah, 32'd0};
    assign w_pp8 = {{15{r2_pl[48]}}, r2_pl} + {r2_ph, 32'd0};
    assign w_c   = r4_ll + {32'(r4_lh + r4_hl), 32'd0};

    // Corrected pressure in Q24.8, then rounding to pascals.
    assign w_s = r5_p + r5_v1 + r5_v2;
    assign w_u = 64'($signed(r6_t + ptc_pkg::ROUND_HALF) >>> 8);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p    <= i_neg ? (64'd0 - i_quo) : i_quo;
            r1_side <= i_side;

            r2_a    <= w_a;
            r2_p    <= r1_p;
            r2_al   <= w_al;
            r2_ah   <= 32'($signed(w_a[63:32]) * $signed(i_coef.p9));
            r2_pl   <= w_pl;
            r2_ph   <= 32'($signed(r1_p[63:32]) * $signed(i_coef.p8));
            r2_side <= r1_side;

            r3_b    <= w_b;
            r3_a    <= r2_a;
            r3_v2   <= 64'($signed(w_pp8) >>> 19);
            r3_p    <= r2_p;
            r3_side <= r2_side;

            r4_ll   <= r3_b[31:0] * r3_a[31:0];
            r4_lh   <= 32'(r3_b[31:0] * r3_a[63:32]);
            r4_hl   <= 32'(r3_b[63:32] * r3_a[31:0]);
            r4_v2   <= r3_v2;
            r4_p    <= r3_p;
            r4_side <= r3_side;

            r5_v1   <= 64'($signed(w_c) >>> 25);
            r5_v2   <= r4_v2;
            r5_p    <= r4_p;
            r5_side <= r4_side;

            r6_t    <= 64'($signed(w_s) >>> 8) + ({{48{i_coef.p7[15]}}, i_coef.p7} << 4);
            r6_side <= r5_side;

            r7_res.status     <= r6_side.status;
            r7_res.temp_centi <= r6_side.temp;
            r7_res.fine_temp  <= r6_side.fine;
            r7_res.pressure   <= r6_side.status ? 32'd0 : w_u[31:0];
        end
    end

    assign o_valid = r_vld[ptc_pkg::BACK_LAT-1];
    assign o_res   = r7_res;

endmodule

`default_nettype wire

FILE: src/pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// pressure_temp_compensation_top: pipelined barometric compensation
// Integer temperature and pressure compensation of raw 20-bit readings with
// twelve packed calibration coefficients, one word per clock unless stalled.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Word
//  input     in         i_in_valid / o_in_ready     i_adc_temp, i_adc_press
//  result    out        o_out_valid / i_out_ready   o_status, o_temp_centi,
//                                                   o_fine_temp, o_pressure
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  One word is accepted per cycle while the output buffer has room; each
//  result passes 13 front stages, 64 divider steps and 7 back stages,
//  the 64-bit divider forming one quotient bit per stage.
//  Reset is synchronous and clears the valid bits, the output buffer and
//  the calibration registers.
//  The pipeline advances as a whole while the two-word output buffer has
//  room, so input is still taken while one result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temp_compensation_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [19:0]  i_adc_temp,
    input  wire logic [19:0]  i_adc_press,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic              o_status,
    output logic [31:0]       o_temp_centi,
    output logic [31:0]       o_fine_temp,
    output logic [31:0]       o_pressure,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);

    logic [47:0] r_temp_calib;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [15:0] r_press_nine;

    ptc_pkg::t_coef   w_coef;
    logic             w_en;

    logic             w_f_valid, w_f_neg;
    logic [63:0]      w_f_num, w_f_den;
    ptc_pkg::t_side   w_f_side;
    logic             w_d_valid, w_d_neg;
    logic [63:0]      w_d_quo;
    ptc_pkg::t_side   w_d_side;
    logic             w_b_valid;
    ptc_pkg::t_result w_b_res;

    logic [1:0]       r_cnt, n_cnt;
    ptc_pkg::t_result r_head, r_tail;
    logic             w_push, w_pop;

    // Calibration registers; indexes beyond the list are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib <= '0;
            r_press_lo   <= '0;
            r_press_hi   <= '0;
            r_press_nine <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ptc_pkg::CFG_TEMP_CALIB: r_temp_calib <= i_cfg_data[47:0];
                ptc_pkg::CFG_PRESS_LO:   r_press_lo   <= i_cfg_data;
                ptc_pkg::CFG_PRESS_HI:   r_press_hi   <= i_cfg_data;
                ptc_pkg::CFG_PRESS_NINE: r_press_nine <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Unpack the coefficients.
    assign w_coef.t1 = r_temp_calib[15:0];
    assign w_coef.t2 = r_temp_calib[31:16];
    assign w_coef.t3 = r_temp_calib[47:32];
    assign w_coef.p1 = r_press_lo[15:0];
    assign w_coef.p2 = r_press_lo[31:16];
    assign w_coef.p3 = r_press_lo[47:32];
    assign w_coef.p4 = r_press_lo[63:48];
    assign w_coef.p5 = r_press_hi[15:0];
    assign w_coef.p6 = r_press_hi[31:16];
    assign w_coef.p7 = r_press_hi[47:32];
    assign w_coef.p8 = r_press_hi[63:48];
    assign w_coef.p9 = r_press_nine;

    // The whole pipeline moves while the output buffer has a free slot.
    assign w_en       = (r_cnt != 2'd2);
    assign o_in_ready = w_en;

    ptc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_in_valid),
        .i_adc_temp  (i_adc_temp),
        .i_adc_press (i_adc_press),
        .i_coef      (w_coef),
        .o_valid     (w_f_valid),
        .o_num       (w_f_num),
        .o_den       (w_f_den),
        .o_neg       (w_f_neg),
        .o_side      (w_f_side)
    );

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_num   (w_f_num),
        .i_den   (w_f_den),
        .i_neg   (w_f_neg),
        .i_side  (w_f_side),
        .o_valid (w_d_valid),
        .o_quo   (w_d_quo),
        .o_neg   (w_d_neg),
        .o_side  (w_d_side)
    );

    ptc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_valid),
        .i_quo   (w_d_quo),
        .i_neg   (w_d_neg),
        .i_side  (w_d_side),
        .i_coef  (w_coef),
        .o_valid (w_b_valid),
        .o_res   (w_b_res)
    );

    // Two-word output buffer: head is presented, tail holds the spare.
    assign w_push = w_b_valid && w_en;
    assign w_pop  = o_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt;
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt == 2'd2) begin
            if (w_pop) begin
                r_head <= r_tail;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0 || w_pop) begin
                r_head <= w_b_res;
            end else begin
                r_tail <= w_b_res;
            end
        end
    end

    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_status     = r_head.status;
    assign o_temp_centi = r_head.temp_centi;
    assign o_fine_temp  = r_head.fine_temp;
    assign o_pressure   = r_head.pressure;

    // The buffer never holds more than two words.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    // A full buffer stays full until a word is taken.
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) && !w_pop |=> (r_cnt == 2'd2))
        else $error("full output buffer changed without a read");

    // A word marked not ready carries no pressure.
    a_status_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> (o_pressure == 32'd0))
        else $error("not-ready word carries a pressure");

endmodule

`default_nettype wire
